// File: rtl/core/tpcf_pkg.sv
// ----------------------------------------------------------------------------
// tpcf_pkg: shared constants for the three-point circle fit
// Fixed-point formats and widths of the centre, square and root paths.
// ----------------------------------------------------------------------------
package tpcf_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned CTR_W     = 64;
  localparam int unsigned MAG_W     = 63;
  localparam logic [MAG_W-1:0] CTR_LIMIT = {1'b0, {(MAG_W-1){1'b1}}};
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned SQ_W      = 128;
  localparam int unsigned ROOT_W    = 64;

endpackage

// File: rtl/core/tpcf_cross.sv
// ----------------------------------------------------------------------------
// tpcf_cross: paraboloid lift and exact cross product
// Six stages: differences, narrow products, lifted z and nz, split products,
// recombination, final differences (nx, ny).
// ----------------------------------------------------------------------------
module tpcf_cross #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic signed [COORD_BITS-1:0]    x1_i,
  input  logic signed [COORD_BITS-1:0]    y1_i,
  input  logic signed [COORD_BITS-1:0]    x2_i,
  input  logic signed [COORD_BITS-1:0]    y2_i,
  input  logic signed [COORD_BITS-1:0]    x3_i,
  input  logic signed [COORD_BITS-1:0]    y3_i,
  output logic                            valid_o,
  output logic signed [3*COORD_BITS+4:0]  nx_o,
  output logic signed [3*COORD_BITS+4:0]  ny_o,
  output logic signed [2*COORD_BITS+2:0]  nz_o,
  output logic signed [COORD_BITS-1:0]    x1_o,
  output logic signed [COORD_BITS-1:0]    y1_o
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned DW = C + 1;
  localparam int unsigned AW = 2 * C + 3;
  localparam int unsigned HW = (AW + 1) / 2;
  localparam int unsigned UW = AW - HW;
  localparam int unsigned PW = DW + AW;
  localparam int unsigned NW = PW + 1;

  logic [5:0] v_q;
  logic signed [C-1:0] x1_q [6];
  logic signed [C-1:0] y1_q [6];

  // stage 1
  logic signed [DW-1:0] ax_q, ay_q, bx_q, by_q, sx2_q, sy2_q, sx3_q, sy3_q;
  // stage 2
  logic signed [2*DW-1:0] p1_q, p2_q, p3_q, p4_q, q1_q, q2_q;
  logic signed [DW-1:0] ax2_q, ay2_q, bx2_q, by2_q;
  // stage 3
  logic signed [AW-1:0] az_q, bz_q;
  logic signed [AW-1:0] nz_q [4];
  logic signed [DW-1:0] ax3_q, ay3_q, bx3_q, by3_q;
  // stage 4
  logic signed [DW+HW:0]   m_aybl_q, m_azbyl_q, m_azbxl_q, m_axbl_q;
  logic signed [DW+UW-1:0] m_aybh_q, m_azbyh_q, m_azbxh_q, m_axbh_q;
  logic signed [HW:0]      bz_lo, az_lo;
  logic signed [UW-1:0]    bz_hi, az_hi;
  // stage 5
  logic signed [PW-1:0] aybz_q, azby_q, azbx_q, axbz_q;
  // stage 6
  logic signed [NW-1:0] nx_q, ny_q;

  assign bz_lo = $signed({1'b0, bz_q[HW-1:0]});
  assign bz_hi = bz_q[AW-1:HW];
  assign az_lo = $signed({1'b0, az_q[HW-1:0]});
  assign az_hi = az_q[AW-1:HW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q[0] <= x1_i;
      y1_q[0] <= y1_i;
      for (int k = 1; k < 6; k++) begin
        x1_q[k] <= x1_q[k-1];
        y1_q[k] <= y1_q[k-1];
      end
      ax_q  <= DW'(x2_i) - DW'(x1_i);
      ay_q  <= DW'(y2_i) - DW'(y1_i);
      bx_q  <= DW'(x3_i) - DW'(x1_i);
      by_q  <= DW'(y3_i) - DW'(y1_i);
      sx2_q <= DW'(x2_i) + DW'(x1_i);
      sy2_q <= DW'(y2_i) + DW'(y1_i);
      sx3_q <= DW'(x3_i) + DW'(x1_i);
      sy3_q <= DW'(y3_i) + DW'(y1_i);

      p1_q  <= ax_q * sx2_q;
      p2_q  <= ay_q * sy2_q;
      p3_q  <= bx_q * sx3_q;
      p4_q  <= by_q * sy3_q;
      q1_q  <= ax_q * by_q;
      q2_q  <= ay_q * bx_q;
      ax2_q <= ax_q;
      ay2_q <= ay_q;
      bx2_q <= bx_q;
      by2_q <= by_q;

      az_q    <= AW'(p1_q) + AW'(p2_q);
      bz_q    <= AW'(p3_q) + AW'(p4_q);
      nz_q[0] <= AW'(q1_q) - AW'(q2_q);
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      bx3_q   <= bx2_q;
      by3_q   <= by2_q;

      m_aybl_q  <= ay3_q * bz_lo;
      m_aybh_q  <= ay3_q * bz_hi;
      m_azbyl_q <= az_lo * by3_q;
      m_azbyh_q <= az_hi * by3_q;
      m_azbxl_q <= az_lo * bx3_q;
      m_azbxh_q <= az_hi * bx3_q;
      m_axbl_q  <= ax3_q * bz_lo;
      m_axbh_q  <= ax3_q * bz_hi;
      nz_q[1]   <= nz_q[0];

      aybz_q  <= (PW'(m_aybh_q) <<< HW) + PW'(m_aybl_q);
      azby_q  <= (PW'(m_azbyh_q) <<< HW) + PW'(m_azbyl_q);
      azbx_q  <= (PW'(m_azbxh_q) <<< HW) + PW'(m_azbxl_q);
      axbz_q  <= (PW'(m_axbh_q) <<< HW) + PW'(m_axbl_q);
      nz_q[2] <= nz_q[1];

      nx_q    <= NW'(aybz_q) - NW'(azby_q);
      ny_q    <= NW'(azbx_q) - NW'(axbz_q);
      nz_q[3] <= nz_q[2];
    end
  end

  assign valid_o = v_q[5];
  assign nx_o    = nx_q;
  assign ny_o    = ny_q;
  assign nz_o    = nz_q[3];
  assign x1_o    = x1_q[5];
  assign y1_o    = y1_q[5];

endmodule

// File: rtl/core/tpcf_div.sv
// ----------------------------------------------------------------------------
// tpcf_div: pipelined restoring divider, two numerators, shared divisor
// One quotient bit per stage; numerator and quotient share a shift word.
// ----------------------------------------------------------------------------
module tpcf_div #(
  parameter int unsigned NUM_W  = 88,
  parameter int unsigned DEN_W  = 51,
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_a_i,
  input  logic [NUM_W-1:0]  num_b_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_a_o,
  output logic [NUM_W-1:0]  quo_b_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W:0]    v_q;
  logic [NUM_W-1:0]  wa_q   [NUM_W+1];
  logic [NUM_W-1:0]  wb_q   [NUM_W+1];
  logic [DEN_W-1:0]  ra_q   [NUM_W+1];
  logic [DEN_W-1:0]  rb_q   [NUM_W+1];
  logic [DEN_W-1:0]  den_q  [NUM_W+1];
  logic [SIDE_W-1:0] side_q [NUM_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NUM_W-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wa_q[0]   <= num_a_i;
      wb_q[0]   <= num_b_i;
      ra_q[0]   <= '0;
      rb_q[0]   <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic [DEN_W:0] ta, tb, da, db, dd;
    logic           ga, gb;

    assign dd = {1'b0, den_q[k]};
    assign ta = {ra_q[k], wa_q[k][NUM_W-1]};
    assign tb = {rb_q[k], wb_q[k][NUM_W-1]};
    assign ga = ta >= dd;
    assign gb = tb >= dd;
    assign da = ta - dd;
    assign db = tb - dd;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[k+1]   <= ga ? da[DEN_W-1:0] : ta[DEN_W-1:0];
        rb_q[k+1]   <= gb ? db[DEN_W-1:0] : tb[DEN_W-1:0];
        wa_q[k+1]   <= {wa_q[k][NUM_W-2:0], ga};
        wb_q[k+1]   <= {wb_q[k][NUM_W-2:0], gb};
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = v_q[NUM_W];
  assign quo_a_o = wa_q[NUM_W];
  assign quo_b_o = wb_q[NUM_W];
  assign side_o  = side_q[NUM_W];

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NUM_W] && den_q[NUM_W] != '0) |->
      (ra_q[NUM_W] < den_q[NUM_W] && rb_q[NUM_W] < den_q[NUM_W]))
    else $error("divider remainder not below divisor");
`endif

endmodule

// File: rtl/core/tpcf_sqrt.sv
// ----------------------------------------------------------------------------
// tpcf_sqrt: pipelined integer square root, two lanes
// One root bit per stage, remainder kept as n - root^2.
// ----------------------------------------------------------------------------
module tpcf_sqrt #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [tpcf_pkg::SQ_W-1:0]   rad_a_i,
  input  logic [tpcf_pkg::SQ_W-1:0]   rad_b_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [tpcf_pkg::ROOT_W-1:0] root_a_o,
  output logic [tpcf_pkg::ROOT_W-1:0] root_b_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned SW = tpcf_pkg::SQ_W;
  localparam int unsigned RW = tpcf_pkg::ROOT_W;

  logic [RW:0]       v_q;
  logic [SW-1:0]     ra_q   [RW+1];
  logic [SW-1:0]     rb_q   [RW+1];
  logic [RW-1:0]     qa_q   [RW+1];
  logic [RW-1:0]     qb_q   [RW+1];
  logic [SIDE_W-1:0] side_q [RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[RW-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_q[0]   <= rad_a_i;
      rb_q[0]   <= rad_b_i;
      qa_q[0]   <= '0;
      qb_q[0]   <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam int unsigned B = RW - 1 - k;
    logic [SW:0] tra, trb;
    logic        ga, gb;

    assign tra = ((SW+1)'(qa_q[k]) << (B + 1)) | ((SW+1)'(1) << (2 * B));
    assign trb = ((SW+1)'(qb_q[k]) << (B + 1)) | ((SW+1)'(1) << (2 * B));
    assign ga  = {1'b0, ra_q[k]} >= tra;
    assign gb  = {1'b0, rb_q[k]} >= trb;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[k+1]   <= ga ? ra_q[k] - tra[SW-1:0] : ra_q[k];
        rb_q[k+1]   <= gb ? rb_q[k] - trb[SW-1:0] : rb_q[k];
        qa_q[k+1]   <= ga ? qa_q[k] | (RW'(1) << B) : qa_q[k];
        qb_q[k+1]   <= gb ? qb_q[k] | (RW'(1) << B) : qb_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o  = v_q[RW];
  assign root_a_o = qa_q[RW];
  assign root_b_o = qb_q[RW];
  assign side_o   = side_q[RW];

`ifndef SYNTH
  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[RW] |-> (ra_q[RW] <= SW'({qa_q[RW], 1'b0}) && rb_q[RW] <= SW'({qb_q[RW], 1'b0})))
    else $error("square root remainder too large");
`endif

endmodule

// File: rtl/core/three_point_circle_fit_tip.sv
// ----------------------------------------------------------------------------
// three_point_circle_fit_tip: circle through three hits, centre, radius, tip
// Exact paraboloid cross product, pipelined division and square roots.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                               tuser
//  s_axis   in   first_x first_y second_x second_y third_x third_y  -
//  m_axis   out  centre_x centre_y circle_radius impact_distance degenerate
//
//  One item per cycle while the output is not stalled. The divider
//  (one quotient bit per stage) and the 64-stage square root make up most of the pipe.
//  Reset clears only valid bits. A stalled output freezes the whole pipe;
//  s_axis_tready is low only while the output item waits.
// ----------------------------------------------------------------------------
module three_point_circle_fit_tip #(
  parameter int unsigned COORD_BITS  = 24,
  parameter int unsigned RESULT_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // centre_x, centre_y, circle_radius, impact_distance
  output logic [((4*RESULT_BITS+7)/8)*8-1:0]    m_axis_tdata,
  // degenerate
  output logic                                  m_axis_tuser
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned R     = RESULT_BITS;
  localparam int unsigned AW    = 2 * C + 3;
  localparam int unsigned NW    = 3 * C + 5;
  localparam int unsigned MW    = NW + tpcf_pkg::FRAC_BITS - 1;
  localparam int unsigned OUT_W = ((4 * R + 7) / 8) * 8;
  localparam int unsigned CW    = tpcf_pkg::CTR_W;
  localparam int unsigned HF    = tpcf_pkg::HALF_W;
  localparam int unsigned SW    = tpcf_pkg::SQ_W;
  localparam int unsigned RW    = tpcf_pkg::ROOT_W;
  localparam int unsigned DS_W  = 2 * C + 3;
  localparam int unsigned QS_W  = 3 + 2 * CW;
  localparam logic [CW-1:0] S_MAX = (CW'(1) << (R - 1)) - CW'(1);
  localparam logic [CW-1:0] U_MAX = (CW'(1) << R) - CW'(1);

  logic pipe_en;
  assign pipe_en       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // cross product
  logic                 cr_valid;
  logic signed [NW-1:0] nx, ny;
  logic signed [AW-1:0] nz;
  logic signed [C-1:0]  cr_x1, cr_y1;

  tpcf_cross #(
    .COORD_BITS (C)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid),
    .x1_i    ($signed(s_axis_tdata[0*C +: C])),
    .y1_i    ($signed(s_axis_tdata[1*C +: C])),
    .x2_i    ($signed(s_axis_tdata[2*C +: C])),
    .y2_i    ($signed(s_axis_tdata[3*C +: C])),
    .x3_i    ($signed(s_axis_tdata[4*C +: C])),
    .y3_i    ($signed(s_axis_tdata[5*C +: C])),
    .valid_o (cr_valid),
    .nx_o    (nx),
    .ny_o    (ny),
    .nz_o    (nz),
    .x1_o    (cr_x1),
    .y1_o    (cr_y1)
  );

  // divider operands
  logic              d_valid_q;
  logic [MW-1:0]     d_num_x_q, d_num_y_q;
  logic [AW-1:0]     d_den_q;
  logic [DS_W-1:0]   d_side_q;
  logic [NW-1:0]     abs_nx, abs_ny;

  assign abs_nx = nx[NW-1] ? NW'(-nx) : NW'(nx);
  assign abs_ny = ny[NW-1] ? NW'(-ny) : NW'(ny);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (pipe_en) begin
      d_valid_q <= cr_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      d_num_x_q <= {abs_nx, {(tpcf_pkg::FRAC_BITS-1){1'b0}}};
      d_num_y_q <= {abs_ny, {(tpcf_pkg::FRAC_BITS-1){1'b0}}};
      d_den_q   <= nz[AW-1] ? AW'(-nz) : AW'(nz);
      d_side_q  <= {(nz == '0) || (nx == '0 && ny == '0),
                    !nx[NW-1] ^ nz[AW-1], !ny[NW-1] ^ nz[AW-1],
                    cr_x1, cr_y1};
    end
  end

  logic            dv_valid;
  logic [MW-1:0]   quo_x, quo_y;
  logic [DS_W-1:0] dv_side;

  tpcf_div #(
    .NUM_W  (MW),
    .DEN_W  (AW),
    .SIDE_W (DS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (d_valid_q),
    .num_a_i (d_num_x_q),
    .num_b_i (d_num_y_q),
    .den_i   (d_den_q),
    .side_i  (d_side_q),
    .valid_o (dv_valid),
    .quo_a_o (quo_x),
    .quo_b_o (quo_y),
    .side_o  (dv_side)
  );

  // centre, offsets, squares
  logic [5:0]                e_v_q;
  logic [5:0]                e_dg_q;
  logic signed [C-1:0]       e1_x1_q, e1_y1_q;
  logic signed [CW-1:0]      e1_cx_q, e1_cy_q, e2_cx_q, e2_cy_q, e2_ux_q, e2_uy_q;
  logic [CW-1:0]             e3_mux_q, e3_muy_q, e3_mcx_q, e3_mcy_q;
  logic [CW-1:0]             e4_mcx_q, e4_mcy_q, e5_mcx_q, e5_mcy_q, e6_mcx_q, e6_mcy_q;
  logic [3:0]                e_sx_q, e_sy_q;
  logic [2*HF-1:0]           e4_hh_q [4];
  logic [2*HF-1:0]           e4_hl_q [4];
  logic [2*HF-1:0]           e4_ll_q [4];
  logic [SW-1:0]             e5_sq_q [4];
  logic [SW-1:0]             e6_rr_q, e6_cc_q;
  logic [tpcf_pkg::MAG_W-1:0] mag_x, mag_y;
  logic [CW-1:0]             e3_in [4];

  assign mag_x = (quo_x > tpcf_pkg::CTR_LIMIT) ? tpcf_pkg::CTR_LIMIT
                                                : tpcf_pkg::MAG_W'(quo_x);
  assign mag_y = (quo_y > tpcf_pkg::CTR_LIMIT) ? tpcf_pkg::CTR_LIMIT
                                                : tpcf_pkg::MAG_W'(quo_y);
  assign e3_in[0] = e3_mux_q;
  assign e3_in[1] = e3_muy_q;
  assign e3_in[2] = e3_mcx_q;
  assign e3_in[3] = e3_mcy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= '0;
    end else if (pipe_en) begin
      e_v_q <= {e_v_q[4:0], dv_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e_dg_q  <= {e_dg_q[4:0], dv_side[DS_W-1]};
      e1_cx_q <= dv_side[DS_W-2] ? CW'(0) - CW'(mag_x) : CW'(mag_x);
      e1_cy_q <= dv_side[DS_W-3] ? CW'(0) - CW'(mag_y) : CW'(mag_y);
      e1_x1_q <= dv_side[2*C-1:C];
      e1_y1_q <= dv_side[C-1:0];

      e2_cx_q <= e1_cx_q;
      e2_cy_q <= e1_cy_q;
      e2_ux_q <= e1_cx_q - (CW'(e1_x1_q) <<< tpcf_pkg::FRAC_BITS);
      e2_uy_q <= e1_cy_q - (CW'(e1_y1_q) <<< tpcf_pkg::FRAC_BITS);

      e3_mux_q <= e2_ux_q[CW-1] ? CW'(-e2_ux_q) : CW'(e2_ux_q);
      e3_muy_q <= e2_uy_q[CW-1] ? CW'(-e2_uy_q) : CW'(e2_uy_q);
      e3_mcx_q <= e2_cx_q[CW-1] ? CW'(-e2_cx_q) : CW'(e2_cx_q);
      e3_mcy_q <= e2_cy_q[CW-1] ? CW'(-e2_cy_q) : CW'(e2_cy_q);
      e_sx_q   <= {e_sx_q[2:0], e2_cx_q[CW-1]};
      e_sy_q   <= {e_sy_q[2:0], e2_cy_q[CW-1]};

      for (int k = 0; k < 4; k++) begin
        e4_hh_q[k] <= e3_in[k][2*HF-1:HF] * e3_in[k][2*HF-1:HF];
        e4_hl_q[k] <= e3_in[k][2*HF-1:HF] * e3_in[k][HF-1:0];
        e4_ll_q[k] <= e3_in[k][HF-1:0] * e3_in[k][HF-1:0];
        e5_sq_q[k] <= (SW'(e4_hh_q[k]) << (2 * HF)) + (SW'(e4_hl_q[k]) << (HF + 1))
                      + SW'(e4_ll_q[k]);
      end
      e4_mcx_q <= e3_mcx_q;
      e4_mcy_q <= e3_mcy_q;
      e5_mcx_q <= e4_mcx_q;
      e5_mcy_q <= e4_mcy_q;

      e6_rr_q  <= e5_sq_q[0] + e5_sq_q[1];
      e6_cc_q  <= e5_sq_q[2] + e5_sq_q[3];
      e6_mcx_q <= e5_mcx_q;
      e6_mcy_q <= e5_mcy_q;
    end
  end

  // square roots
  logic            sq_valid;
  logic [RW-1:0]   r12, c12;
  logic [QS_W-1:0] sq_side;

  tpcf_sqrt #(
    .SIDE_W (QS_W)
  ) u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (pipe_en),
    .valid_i  (e_v_q[5]),
    .rad_a_i  (e6_rr_q),
    .rad_b_i  (e6_cc_q),
    .side_i   ({e_dg_q[5], e_sx_q[3], e_sy_q[3], e6_mcx_q, e6_mcy_q}),
    .valid_o  (sq_valid),
    .root_a_o (r12),
    .root_b_o (c12),
    .side_o   (sq_side)
  );

  // output scaling and saturation
  logic          g_valid_q, g_dg_q, g_sx_q, g_sy_q;
  logic [CW-1:0] g_wx_q, g_wy_q, g_rad_q, g_tip_q;
  logic [R-1:0]  o_cx, o_cy, o_rad, o_tip;
  logic          out_valid_q, out_dg_q;
  logic [OUT_W-1:0] out_data_q;

  always_comb begin
    if (!g_sx_q && g_wx_q > S_MAX) begin
      o_cx = R'(S_MAX);
    end else if (g_sx_q && g_wx_q > S_MAX + CW'(1)) begin
      o_cx = R'(CW'(0) - S_MAX - CW'(1));
    end else begin
      o_cx = g_sx_q ? R'(CW'(0) - g_wx_q) : R'(g_wx_q);
    end
    if (!g_sy_q && g_wy_q > S_MAX) begin
      o_cy = R'(S_MAX);
    end else if (g_sy_q && g_wy_q > S_MAX + CW'(1)) begin
      o_cy = R'(CW'(0) - S_MAX - CW'(1));
    end else begin
      o_cy = g_sy_q ? R'(CW'(0) - g_wy_q) : R'(g_wy_q);
    end
    o_rad = (g_rad_q > U_MAX) ? R'(U_MAX) : R'(g_rad_q);
    o_tip = (g_tip_q > U_MAX) ? R'(U_MAX) : R'(g_tip_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      g_valid_q   <= sq_valid;
      out_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      g_dg_q  <= sq_side[QS_W-1];
      g_sx_q  <= sq_side[QS_W-2];
      g_sy_q  <= sq_side[QS_W-3];
      g_wx_q  <= sq_side[2*CW-1:CW] >> tpcf_pkg::FRAC_BITS;
      g_wy_q  <= sq_side[CW-1:0] >> tpcf_pkg::FRAC_BITS;
      g_rad_q <= CW'(r12 >> tpcf_pkg::FRAC_BITS);
      g_tip_q <= CW'(((c12 >= r12) ? c12 - r12 : r12 - c12) >> tpcf_pkg::FRAC_BITS);

      out_dg_q   <= g_dg_q;
      out_data_q <= g_dg_q ? '0 : OUT_W'({o_tip, o_rad, o_cy, o_cx});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_dg_q;

`ifndef SYNTH
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("degenerate item with nonzero fields");
`endif

endmodule

// File: test/three_point_circle_fit_tip_chk.sv
// ----------------------------------------------------------------------------
// three_point_circle_fit_tip_chk: result checker for the circle fit
// Watches both channels, predicts centre, radius, impact parameter and the
// degenerate flag for every accepted item, and compares in order.
// ----------------------------------------------------------------------------
module three_point_circle_fit_tip_chk (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // first_x, first_y, second_x, second_y, third_x, third_y
  input  logic [143:0] s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // centre_x, centre_y, circle_radius, impact_distance
  input  logic [127:0] m_axis_tdata,
  // degenerate
  input  logic         m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o,
  output int           fit_count_o,
  output int           degen_count_o
);

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] radius;
    logic [31:0] impact;
    logic        degen;
  } fit_t;

  fit_t fit_q[$];

  function automatic logic signed [63:0] centre_q12(logic signed [127:0] nc,
                                                     logic signed [127:0] nz);
    logic signed [127:0] num;
    logic [127:0] q;
    logic [63:0] m;
    logic neg;
    num = -nc * 128'sd2048;
    neg = num[127] != nz[127];
    q = (num[127] ? -num : num) / (nz[127] ? -nz : nz);
    m = (q > {64'd0, 1'b0, tpcf_pkg::CTR_LIMIT}) ? {1'b0, tpcf_pkg::CTR_LIMIT} : q[63:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [63:0] int_root(logic [127:0] n);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (n >= {64'd0, c} * {64'd0, c}) res = c;
    end
    return res;
  endfunction

  function automatic logic [127:0] sq_mag(logic signed [63:0] v);
    logic [127:0] m;
    m = v[63] ? {64'd0, -v} : {64'd0, v};
    return m * m;
  endfunction

  function automatic logic [31:0] whole_signed(logic signed [63:0] c);
    logic signed [63:0] w;
    w = c[63] ? -$signed((-c) >> tpcf_pkg::FRAC_BITS) : (c >> tpcf_pkg::FRAC_BITS);
    if (w > 64'sd2147483647) w = 64'sd2147483647;
    if (w < -64'sd2147483648) w = -64'sd2147483648;
    return w[31:0];
  endfunction

  function automatic logic [31:0] whole_unsigned(logic [63:0] v);
    logic [63:0] w;
    w = v >> tpcf_pkg::FRAC_BITS;
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic fit_t predict_fit(logic [143:0] d);
    logic signed [63:0] x1, y1, x2, y2, x3, y3, ax, ay, bx, by, cx, cy, ux, uy;
    logic signed [127:0] az, bz, nx, ny, nz;
    logic [63:0] r12, c12;
    fit_t f;
    x1 = $signed(d[23:0]);    y1 = $signed(d[47:24]);
    x2 = $signed(d[71:48]);   y2 = $signed(d[95:72]);
    x3 = $signed(d[119:96]);  y3 = $signed(d[143:120]);
    ax = x2 - x1; ay = y2 - y1; bx = x3 - x1; by = y3 - y1;
    az = 128'(ax) * 128'(x1 + x2) + 128'(ay) * 128'(y1 + y2);
    bz = 128'(bx) * 128'(x1 + x3) + 128'(by) * 128'(y1 + y3);
    nx = 128'(ay) * bz - az * 128'(by);
    ny = az * 128'(bx) - 128'(ax) * bz;
    nz = 128'(ax) * 128'(by) - 128'(ay) * 128'(bx);
    f = '0;
    if (nz == 0 || (nx == 0 && ny == 0)) begin
      f.degen = 1'b1;
      return f;
    end
    cx = centre_q12(nx, nz);
    cy = centre_q12(ny, nz);
    ux = cx - (x1 <<< tpcf_pkg::FRAC_BITS);
    uy = cy - (y1 <<< tpcf_pkg::FRAC_BITS);
    r12 = int_root(sq_mag(ux) + sq_mag(uy));
    c12 = int_root(sq_mag(cx) + sq_mag(cy));
    f.cx = whole_signed(cx);
    f.cy = whole_signed(cy);
    f.radius = whole_unsigned(r12);
    f.impact = whole_unsigned(c12 >= r12 ? c12 - r12 : r12 - c12);
    return f;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    fail_count_o++;
  endtask

  assign pending_o = fit_q.size();

  always @(posedge clk_i) begin
    fit_t want;
    if (!rst_ni) begin
      fail_count_o = 0;
      fit_count_o = 0;
      degen_count_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) fit_q = {fit_q, predict_fit(s_axis_tdata)};
      if (m_axis_tvalid && m_axis_tready) begin
        if (fit_q.size() == 0) begin
          report("unexpected item", m_axis_tdata[31:0], 32'd0);
        end else begin
          want = fit_q.pop_front();
          if (want.degen) degen_count_o++;
          else fit_count_o++;
          if (m_axis_tuser !== want.degen) report("degenerate", m_axis_tuser, want.degen);
          if (m_axis_tdata[31:0] !== want.cx) report("centre_x", m_axis_tdata[31:0], want.cx);
          if (m_axis_tdata[63:32] !== want.cy) report("centre_y", m_axis_tdata[63:32], want.cy);
          if (m_axis_tdata[95:64] !== want.radius)
            report("circle_radius", m_axis_tdata[95:64], want.radius);
          if (m_axis_tdata[127:96] !== want.impact)
            report("impact_distance", m_axis_tdata[127:96], want.impact);
        end
      end
    end
  end
endmodule

// File: test/tb_three_point_circle_fit_tip.sv
// ----------------------------------------------------------------------------
// tb_three_point_circle_fit_tip: testbench for the three-point circle fit
// Directed corner triplets, then random triplets of several shapes, sent in
// bursts against a stalling receiver; a checker compares every result.
// ----------------------------------------------------------------------------
module tb_three_point_circle_fit_tip;
  localparam int NUM_RANDOM = 1450;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic         m_axis_tuser;
  int           fail_count, pending, fit_count, degen_count;
  int           cycles = 0;
  int           burst_left = 0;
  int           stall_mode = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  three_point_circle_fit_tip DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  three_point_circle_fit_tip_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending),
    .fit_count_o(fit_count), .degen_count_o(degen_count)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (cycles % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: m_axis_tready <= ((cycles / 23) % 3 == 0);
    endcase
  end

  task automatic send_hits(logic [23:0] x1, logic [23:0] y1, logic [23:0] x2,
                           logic [23:0] y2, logic [23:0] x3, logic [23:0] y3);
    int gap;
    s_axis_tdata <= {y3, x3, y2, x2, y1, x1};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  function automatic logic [23:0] rnd_small(int span);
    return 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_random();
    logic [23:0] x1, y1, dx, dy;
    case ($urandom_range(0, 9))
      0, 1, 2: send_hits(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom), 24'($urandom));
      3, 4, 5: begin
        x1 = rnd_small(200000); y1 = rnd_small(200000);
        send_hits(x1, y1, x1 + rnd_small(5000), y1 + rnd_small(5000),
                  x1 + rnd_small(10000), y1 + rnd_small(10000));
      end
      6, 7: begin
        x1 = 24'($urandom); y1 = 24'($urandom);
        dx = rnd_small(100000); dy = rnd_small(100000);
        send_hits(x1, y1, x1 + dx, y1 + dy, 24'(x1 + 2 * dx + rnd_small(2)),
                  24'(y1 + 2 * dy + rnd_small(2)));
      end
      8: send_hits(rnd_small(4), rnd_small(4), rnd_small(4), rnd_small(4),
                   rnd_small(4), rnd_small(4));
      default: begin
        x1 = rnd_small(3000000);
        send_hits(x1, 0, 0, x1, -x1, rnd_small(1));
      end
    endcase
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_hits(0, 0, 0, 0, 0, 0);
    send_hits(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_hits(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
    send_hits(1000, 0, 0, 1000, -1000, 0);
    send_hits(0, 5, 5, 0, 0, -5);
    send_hits(1, 1, 2, 2, 3, 3);
    send_hits(-7, 3, -7, 3, 100, 200);
    send_hits(10, 20, 10, 20, 10, 20);
    send_hits(0, 0, 24'h7FFFFF, 1, 24'h800000, 0);
    send_hits(-4000000, 0, 0, 1, 4000000, 0);
    send_hits(1, 0, 0, 1, 0, 0);
    send_hits(100, 100, 101, 100, 100, 101);
    send_hits(24'h7FFFFF, 0, 0, 24'h7FFFFF, 24'h800000, 0);
    send_hits(3000, 4000, -3000, 4000, 3000, -4000);
    send_hits(-1, -1, 1, -1, -1, 1);
    send_hits(5000000, 5000000, 5000001, 5000003, 5000002, 5000006);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      send_random();
      if (i == NUM_RANDOM / 2) begin
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("covered %0d fitted circles and %0d degenerate triplets", fit_count,
             degen_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/tpcf_pkg.sv
rtl/core/tpcf_cross.sv
rtl/core/tpcf_div.sv
rtl/core/tpcf_sqrt.sv
rtl/core/three_point_circle_fit_tip.sv
test/three_point_circle_fit_tip_chk.sv
test/tb_three_point_circle_fit_tip.sv
